[rtl/core/ppsc_pkg.sv]
// Package for the pulse-pattern shut-off controller.
// Holds the phase encoding, request kinds, register indexes and the shared structs.
// No dependencies.
package ppsc_pkg;

    localparam int unsigned CFG_W   = 20;
    localparam int unsigned INDEX_W = 3;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_MEASURE = 4'b0010,
        ST_WAIT    = 4'b0100,
        ST_CUT     = 4'b1000
    } ppsc_state_t;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_MEASURE = 2'd1;
    localparam logic [1:0] PHASE_WAIT    = 2'd2;
    localparam logic [1:0] PHASE_CUT     = 2'd3;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    localparam logic [INDEX_W-1:0] REG_INVERT_INPUT   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_INVERT_OUTPUT  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_ACTIVE_LEVEL   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_PULSE_MIN      = 3'd3;
    localparam logic [INDEX_W-1:0] REG_PULSE_MAX      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_WAIT_TIME      = 3'd5;
    localparam logic [INDEX_W-1:0] REG_WAIT_TOLERANCE = 3'd6;
    localparam logic [INDEX_W-1:0] REG_CUT_DURATION   = 3'd7;

    typedef struct packed {
        logic             invert_input;
        logic             invert_output;
        logic             active_level;
        logic [CFG_W-1:0] pulse_min;
        logic [CFG_W-1:0] pulse_max;
        logic [CFG_W-1:0] wait_time;
        logic [CFG_W-1:0] wait_tolerance;
        logic [CFG_W-1:0] cut_duration;
    } ppsc_cfg_t;

    typedef struct packed {
        logic             drive_level;
        logic [1:0]       phase;
        logic [CFG_W-1:0] last_pulse_width;
    } ppsc_result_t;

endpackage

[rtl/core/ppsc_if.sv]
// Channel interfaces of the pulse-pattern shut-off controller.
// Sample requests, result requests and register writes; depends on ppsc_pkg.
interface ppsc_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic input_level;

    modport source (output valid, output kind, output input_level, input ready);
    modport sink (input valid, input kind, input input_level, output ready);
endinterface

interface ppsc_out_if import ppsc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             drive_level;
    logic [1:0]       phase;
    logic [CFG_W-1:0] last_pulse_width;

    modport source (output valid, output drive_level, output phase,
                    output last_pulse_width, input ready);
    modport sink (input valid, input drive_level, input phase,
                  input last_pulse_width, output ready);
endinterface

interface ppsc_cfg_if import ppsc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/ppsc_engine.sv]
// Tick engine of the pulse-pattern shut-off controller: phase FSM, time-since-edge counter,
// pulse width and cut counter, updated once per request. Depends on ppsc_pkg.
module ppsc_engine import ppsc_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic         kind,
    input  logic         input_level,
    input  ppsc_cfg_t    cfg_regs,
    output ppsc_result_t result_next
);

    localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W + 1) ? TIME_WIDTH : CFG_W + 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    ppsc_state_t           state_reg, state_next;
    logic                  entry_reg, entry_next;
    logic                  level_reg, level_next;
    logic [TIME_WIDTH-1:0] tse_reg, tse_next;
    logic [TIME_WIDTH-1:0] pw_reg, pw_next;
    logic [TIME_WIDTH-1:0] ce_reg, ce_next;

    logic                  level;
    logic                  changed;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] ce_step;
    logic [CMP_W-1:0]      elapsed_x;
    logic [CMP_W-1:0]      pw_x;
    logic [CMP_W-1:0]      ce_x;
    logic [CMP_W-1:0]      window_x;
    logic [1:0]            phase_code;

    always_comb
    begin
        level     = input_level ^ cfg_regs.invert_input;
        changed   = level != level_reg;
        elapsed   = (tse_reg == TIME_MAX) ? tse_reg : tse_reg + 1'b1;
        elapsed_x = CMP_W'(elapsed);
        window_x  = CMP_W'({1'b0, cfg_regs.wait_time})
                  + CMP_W'({1'b0, cfg_regs.wait_tolerance});

        state_next = state_reg;
        level_next = level;
        tse_next   = changed ? '0 : elapsed;
        pw_next    = (changed && level_reg == cfg_regs.active_level) ? elapsed : pw_reg;
        pw_x       = CMP_W'(pw_next);
        ce_next    = ce_reg;
        ce_step    = (ce_reg == TIME_MAX) ? ce_reg : ce_reg + 1'b1;
        ce_x       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (changed && level == cfg_regs.active_level)
                begin
                    state_next = ST_MEASURE;
                end
            end
            ST_MEASURE:
            begin
                if (changed)
                begin
                    if (level == cfg_regs.active_level)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pw_x < CMP_W'(cfg_regs.pulse_min)
                             || pw_x > CMP_W'(cfg_regs.pulse_max))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (elapsed_x >= CMP_W'(cfg_regs.wait_time))
                begin
                    if (elapsed_x > window_x)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (changed)
                    begin
                        state_next = (level != cfg_regs.active_level) ? ST_IDLE : ST_CUT;
                    end
                end
            end
            ST_CUT:
            begin
                ce_next = entry_reg ? '0 : ce_step;
                ce_x    = CMP_W'(ce_next);
                if (ce_x >= CMP_W'(cfg_regs.cut_duration))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        entry_next = state_next != state_reg;

        if (kind == KIND_RESET)
        begin
            state_next = ST_IDLE;
            entry_next = 1'b1;
            level_next = level_reg;
            tse_next   = '0;
            pw_next    = '0;
            ce_next    = '0;
        end

        unique case (state_next)
            ST_IDLE:    phase_code = PHASE_IDLE;
            ST_MEASURE: phase_code = PHASE_MEASURE;
            ST_WAIT:    phase_code = PHASE_WAIT;
            ST_CUT:     phase_code = PHASE_CUT;
            default:    phase_code = PHASE_IDLE;
        endcase

        result_next.drive_level      = (state_next == ST_CUT) ^ cfg_regs.invert_output;
        result_next.phase            = phase_code;
        result_next.last_pulse_width = pw_x[CFG_W-1:0] & {CFG_W{kind == KIND_TICK}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            entry_reg <= 1'b1;
            level_reg <= 1'b0;
            tse_reg   <= '0;
            pw_reg    <= '0;
            ce_reg    <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            level_reg <= level_next;
            tse_reg   <= tse_next;
            pw_reg    <= pw_next;
            ce_reg    <= ce_next;
        end
    end

    // A soft reset request leaves the engine idle with cleared counters.
    a_soft_reset: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && kind == KIND_RESET |=> state_reg == ST_IDLE && tse_reg == '0
                                          && pw_reg == '0 && ce_reg == '0)
        else $error("soft reset did not clear the engine");

    // Shut-off is entered only from the waiting window.
    a_cut_entry: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && state_reg != ST_WAIT && state_reg != ST_CUT |=> state_reg != ST_CUT)
        else $error("shut-off entered from a phase other than waiting");

    // Without a request the state does not move.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(state_reg) && $stable(tse_reg) && $stable(ce_reg))
        else $error("engine state changed without a request");

    // Every phase change marks the new phase as freshly entered.
    a_entry_mark: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && state_next != state_reg |=> entry_reg)
        else $error("phase change without entry mark");

endmodule

[rtl/core/pulse_pattern_shutoff_controller_top.sv]
// Top level of the pulse-pattern shut-off controller.
// Depends on ppsc_pkg, the interfaces in ppsc_if and ppsc_engine.
//
// Usage: each request on the sample channel is either a one-millisecond tick
// carrying the raw input level, or a soft reset that returns the FSM to idle.
// Every request yields exactly one request on the result channel with the
// output drive level, the phase code and the width of the last active pulse.
// Registers are written over the cfg channel, which is always ready; writes
// are meant to happen while no request is in flight.
// A request passes through an input register, then the engine logic feeding the
// result register. Throughput is one request per clock while the result
// receiver is not stalling.
// When the result receiver stalls, the result register holds and the input
// register still takes one more request; sample ready drops only when both
// are full. An asynchronous reset clears the valid flags and engine state and
// loads the reset values: active level high, widest pulse range, all times zero.
module pulse_pattern_shutoff_controller_top import ppsc_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    ppsc_in_if.sink     sample,
    ppsc_out_if.source  result,
    ppsc_cfg_if.sink    cfg
);

    ppsc_cfg_t    cfg_reg, cfg_next;
    ppsc_result_t res_comb;
    ppsc_result_t res_reg;

    logic s1_valid_reg;
    logic s1_kind_reg;
    logic s1_level_reg;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic step_en;
    logic s1_load;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_INVERT_INPUT:   cfg_next.invert_input   = cfg.data[0];
                REG_INVERT_OUTPUT:  cfg_next.invert_output  = cfg.data[0];
                REG_ACTIVE_LEVEL:   cfg_next.active_level   = cfg.data[0];
                REG_PULSE_MIN:      cfg_next.pulse_min      = cfg.data;
                REG_PULSE_MAX:      cfg_next.pulse_max      = cfg.data;
                REG_WAIT_TIME:      cfg_next.wait_time      = cfg.data;
                REG_WAIT_TOLERANCE: cfg_next.wait_tolerance = cfg.data;
                REG_CUT_DURATION:   cfg_next.cut_duration   = cfg.data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_input   <= 1'b0;
            cfg_reg.invert_output  <= 1'b0;
            cfg_reg.active_level   <= 1'b1;
            cfg_reg.pulse_min      <= '0;
            cfg_reg.pulse_max      <= '1;
            cfg_reg.wait_time      <= '0;
            cfg_reg.wait_tolerance <= '0;
            cfg_reg.cut_duration   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance      = !out_valid_reg || result.ready;
    assign step_en      = s1_valid_reg && advance;
    assign sample.ready = !s1_valid_reg || advance;
    assign s1_load      = sample.valid && sample.ready;

    always_comb
    begin
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg  <= sample.kind;
            s1_level_reg <= sample.input_level;
        end
        if (step_en)
        begin
            res_reg <= res_comb;
        end
    end

    ppsc_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .kind        (s1_kind_reg),
        .input_level (s1_level_reg),
        .cfg_regs    (cfg_reg),
        .result_next (res_comb)
    );

    assign result.valid            = out_valid_reg;
    assign result.drive_level      = res_reg.drive_level;
    assign result.phase            = res_reg.phase;
    assign result.last_pulse_width = res_reg.last_pulse_width;

    // A stalled result is never overwritten by a new engine step.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !step_en)
        else $error("engine stepped into a stalled result register");

    // A pending input request moves on whenever the result side can take it.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |-> step_en)
        else $error("pending request not forwarded to an empty result register");

    // The input side is refused only when both stages are full and stalled.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> s1_valid_reg && out_valid_reg && !result.ready)
        else $error("sample ready dropped without a full pipeline");

endmodule
